// File: rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic timer table: action and status
// codes, field widths and the command/status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // table sizing
  localparam int MAX_TIMERS_DEF = 16;
  localparam int LIVE_CAP       = 16;   // slot ids are 4 bits wide
  localparam int LIVE_W         = 5;    // holds a live count up to 16

  // field widths
  localparam int ACT_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;
  localparam int REP_W    = 17;
  localparam int TAG_W    = 16;
  localparam int STAT_W   = 2;

  // configuration
  localparam logic [LIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam int                APB_ADDR_W   = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CHANGE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ARGS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT  = 2'd3;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  localparam logic signed [REP_W-1:0] REPEAT_FOREVER = -17'sd1;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the request, clear the walk index
    logic exec;    // carry out a create/change/delete/reset
    logic step;    // tick one slot, advance the walk
    logic flush;   // give out the held fire result as the last one
  } ptt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;  // walk index sits on the highest live slot
  } ptt_stat_t;

endpackage

// File: rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer of the timer table: accepts a request, then either runs one
// operation in its exec state or walks the live slots for a tick and flushes.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                is_tick,
  input  ptt_pkg::ptt_stat_t  stat,
  output logic                busy,
  output ptt_pkg::ptt_cmd_t   cmd
);
  import ptt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_tick ? S_WALK : S_EXEC;
        end
      end
      S_WALK: begin
        if (stat.walk_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands
  assign cmd.load  = accept;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.step  = (state == S_WALK);
  assign cmd.flush = (state == S_FLUSH);

endmodule

// File: rtl/ptt_dp.sv
// ----------------------------------------------------------------------------
// ptt_dp
// Datapath of the timer table: request registers, slot table, walk index,
// held fire result and the registered result ports.
// ----------------------------------------------------------------------------
module ptt_dp #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ptt_pkg::ptt_cmd_t                   cmd,
  output ptt_pkg::ptt_stat_t                  stat,
  input  logic [ptt_pkg::LIVE_W-1:0]          active_timers,
  input  logic [ptt_pkg::ACT_W-1:0]           action,
  input  logic [ptt_pkg::SLOT_W-1:0]          timer_id,
  input  logic [ptt_pkg::PERIOD_W-1:0]        period,
  input  logic signed [ptt_pkg::REP_W-1:0]    repeat_count,
  input  logic [ptt_pkg::TAG_W-1:0]           handler_tag,
  input  logic                                handler_valid,
  output logic                                strobe,
  output logic                                result_kind,
  output logic [ptt_pkg::SLOT_W-1:0]          slot_id,
  output logic [ptt_pkg::TAG_W-1:0]           fired_tag,
  output logic [ptt_pkg::STAT_W-1:0]          status,
  output logic                                last
);
  import ptt_pkg::*;

  localparam int SLOTS = (MAX_TIMERS < LIVE_CAP) ? MAX_TIMERS : LIVE_CAP;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // request registers
  logic [ACT_W-1:0]        req_act;
  logic [SLOT_W-1:0]       req_id;
  logic [PERIOD_W-1:0]     req_period;
  logic signed [REP_W-1:0] req_rep;
  logic [TAG_W-1:0]        req_tag;
  logic                    req_tag_valid;

  // slot table
  logic [SLOTS-1:0]        used;
  logic [PERIOD_W-1:0]     tbl_period [SLOTS];
  logic [PERIOD_W-1:0]     tbl_rem    [SLOTS];
  logic signed [REP_W-1:0] tbl_rep    [SLOTS];
  logic [TAG_W-1:0]        tbl_tag    [SLOTS];

  // walk and held fire result
  logic [IDX_W-1:0]  walk;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_slot;
  logic [TAG_W-1:0]  pend_tag;

  logic [LIVE_W-1:0]       n_live;
  logic [IDX_W-1:0]        free_idx;
  logic                    free_found;
  logic [IDX_W-1:0]        id_idx;
  logic [IDX_W-1:0]        sel;
  logic                    in_range;
  logic                    id_used;
  logic                    rep_lt_m1;
  logic                    rep_ok;
  logic                    cur_used;
  logic                    fire;
  logic signed [REP_W-1:0] rep_dec;

  // operation outcome
  logic               wr_all;
  logic               set_used;
  logic               clr_used;
  logic               wr_chg;
  logic [STAT_W-1:0]  op_status;
  logic [SLOT_W-1:0]  op_slot;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act       <= action;
      req_id        <= timer_id;
      req_period    <= period;
      req_rep       <= repeat_count;
      req_tag       <= handler_tag;
      req_tag_valid <= handler_valid;
    end
  end

  // live slot count, clamped to 1..SLOTS
  always_comb begin
    if (active_timers == '0) begin
      n_live = LIVE_W'(1);
    end else if (active_timers > LIVE_W'(SLOTS)) begin
      n_live = LIVE_W'(SLOTS);
    end else begin
      n_live = active_timers;
    end
  end

  // lowest free live slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i] && (LIVE_W'(i) < n_live)) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign id_idx    = req_id[IDX_W-1:0];
  assign in_range  = ({1'b0, req_id} < n_live);
  assign id_used   = in_range && used[id_idx];
  assign rep_lt_m1 = req_rep[REP_W-1] && (req_rep != REPEAT_FOREVER);
  assign rep_ok    = !rep_lt_m1 && (req_rep != '0);

  // one table port: walk index, created slot or addressed slot
  always_comb begin
    if (cmd.exec) begin
      sel = (req_act == ACT_CREATE) ? free_idx : id_idx;
    end else begin
      sel = walk;
    end
  end

  // tick of the walked slot
  assign cur_used = used[sel];
  assign fire     = cur_used && (tbl_rem[sel][PERIOD_W-1:1] == '0);
  assign rep_dec  = (tbl_rep[sel] == REPEAT_FOREVER) ? tbl_rep[sel]
                                                     : tbl_rep[sel] - REP_W'(1);

  // operation decode
  always_comb begin
    wr_all    = 1'b0;
    set_used  = 1'b0;
    clr_used  = 1'b0;
    wr_chg    = 1'b0;
    op_status = ST_OK;
    op_slot   = req_id;
    case (req_act)
      ACT_CREATE: begin
        op_slot = '0;
        if ((req_period == '0) || !rep_ok) begin
          op_status = ST_BAD_ARGS;
        end else if (!free_found) begin
          op_status = ST_FULL;
        end else begin
          op_slot  = SLOT_W'(free_idx);
          wr_all   = 1'b1;
          set_used = 1'b1;
        end
      end
      ACT_CHANGE: begin
        if (!id_used) begin
          op_status = ST_BAD_SLOT;
        end else if (rep_lt_m1) begin
          op_status = ST_BAD_ARGS;
        end else begin
          wr_chg = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (!in_range) begin
          op_status = ST_BAD_SLOT;
        end else begin
          clr_used = 1'b1;
        end
      end
      ACT_RESET: begin
        if (!in_range) begin
          op_status = ST_BAD_SLOT;
        end else if (!rep_ok) begin
          op_status = ST_BAD_ARGS;
        end else if (!id_used) begin
          op_status = ST_BAD_SLOT;
        end else begin
          wr_all = 1'b1;
        end
      end
      default: begin
        op_status = ST_BAD_ARGS;
        op_slot   = '0;
      end
    endcase
  end

  // slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec && set_used) begin
      used[sel] <= 1'b1;
    end else if (cmd.exec && clr_used) begin
      used[sel] <= 1'b0;
    end else if (cmd.step && fire && (rep_dec == '0)) begin
      used[sel] <= 1'b0;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_all) begin
      tbl_period[sel] <= req_period;
      tbl_rem[sel]    <= req_period;
      tbl_rep[sel]    <= req_rep;
      tbl_tag[sel]    <= req_tag;
    end else if (cmd.exec && wr_chg) begin
      if (req_tag_valid) begin
        tbl_tag[sel] <= req_tag;
      end
      if (req_period != '0) begin
        tbl_period[sel] <= req_period;
        tbl_rem[sel]    <= req_period;
      end
      if (req_rep != '0) begin
        tbl_rep[sel] <= req_rep;
      end
    end else if (cmd.step && cur_used) begin
      if (fire) begin
        tbl_rep[sel] <= rep_dec;
        if (rep_dec != '0) begin
          tbl_rem[sel] <= tbl_period[sel];
        end
      end else begin
        tbl_rem[sel] <= tbl_rem[sel] - PERIOD_W'(1);
      end
    end
  end

  // walk index
  assign stat.walk_last = (LIVE_W'(walk) == (n_live - LIVE_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      walk <= '0;
    end else if (cmd.step && !stat.walk_last) begin
      walk <= walk + IDX_W'(1);
    end
  end

  // held fire result: only known to be the last once the walk ends
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && fire) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && fire) begin
      pend_slot <= sel;
      pend_tag  <= tbl_tag[sel];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.exec || ((cmd.step && fire) || cmd.flush) && pend_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_kind <= KIND_STATUS;
      slot_id     <= op_slot;
      fired_tag   <= '0;
      status      <= op_status;
      last        <= 1'b1;
    end else begin
      result_kind <= KIND_FIRED;
      slot_id     <= SLOT_W'(pend_slot);
      fired_tag   <= pend_tag;
      status      <= ST_OK;
      last        <= cmd.flush;
    end
  end

endmodule

// File: rtl/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timer slots with repeat counts, driven by tick, create,
// change, delete and reset requests; APB register for the live slot count.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Create, change,
// delete and reset keep the block busy in the exec state and give one status
// result in the cycle after it; an unknown action code does the same with a
// bad-args status. A tick walks the live slots one per cycle, then flushes;
// the live slot count is 1..16, and at most MAX_TIMERS. Each fired timer
// gives one result; the last flag marks the final one, and a tick that fires
// nothing gives no result. Every result is on the ports for exactly one
// cycle, marked by strobe, and must be taken then: there is no way to hold
// it off. Fire results come out in ascending slot order, the last at the
// flush. Write active_timers only while the block is idle.
module periodic_timer_table #(
  parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic [ptt_pkg::ACT_W-1:0]           action,
  input  logic [ptt_pkg::SLOT_W-1:0]          timer_id,
  input  logic [ptt_pkg::PERIOD_W-1:0]        period,
  input  logic signed [ptt_pkg::REP_W-1:0]    repeat_count,
  input  logic [ptt_pkg::TAG_W-1:0]           handler_tag,
  input  logic                                handler_valid,
  // results
  output logic                                strobe,
  output logic                                result_kind,
  output logic [ptt_pkg::SLOT_W-1:0]          slot_id,
  output logic [ptt_pkg::TAG_W-1:0]           fired_tag,
  output logic [ptt_pkg::STAT_W-1:0]          status,
  output logic                                last,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptt_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ptt_pkg::*;

  logic [LIVE_W-1:0] active_timers;
  logic              cfg_wr;
  ptt_cmd_t          cmd;
  ptt_stat_t         stat;

  // register at byte address 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_timers <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_timers <= pwdata[LIVE_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32-LIVE_W){1'b0}}, active_timers};

  ptt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_tick (action == ACT_TICK),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  ptt_dp #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .active_timers (active_timers),
    .action        (action),
    .timer_id      (timer_id),
    .period        (period),
    .repeat_count  (repeat_count),
    .handler_tag   (handler_tag),
    .handler_valid (handler_valid),
    .strobe        (strobe),
    .result_kind   (result_kind),
    .slot_id       (slot_id),
    .fired_tag     (fired_tag),
    .status        (status),
    .last          (last)
  );

endmodule
